### rtl/mles_pkg.sv
// Package for the modular linear equation solver.
// Holds the status codes; no dependencies.
`default_nettype none
package mles_pkg;
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_DIV   = 2'd1;
   localparam logic [1:0] STATUS_BAD_IDX  = 2'd2;
endpackage
`default_nettype wire

### rtl/modular_linear_equation_solver.sv
// Modular linear equation solver, top level: extended Euclid then solution.
// Depends on mles_pkg and mles_div (shared restoring divider).
// One transaction at a time. Each Euclid step starts the shared divider, waits
// for its quotient and remainder, then runs two multiply-subtract states; there
// are at most about 1.44*DATA_WIDTH steps. The solution phase adds six chained
// divisions and two bit-serial modular products. An item also passes through
// the check, accept, final add and output states.
// req_ready is high only while idle. The result waits in an output register
// until taken, so the next transaction may start; it stalls in its last cycle
// only while the previous result is still unclaimed.
`default_nettype none
module modular_linear_equation_solver #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [DATA_WIDTH-1:0] req_coef_a,
   input  wire logic [DATA_WIDTH-1:0] req_rhs_b,
   input  wire logic [DATA_WIDTH-1:0] req_modulus,
   input  wire logic [DATA_WIDTH-1:0] req_solution_index,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0]      rsp_gcd_value,
   output logic signed [DATA_WIDTH:0] rsp_bezout_x,
   output logic signed [DATA_WIDTH:0] rsp_bezout_y,
   output logic [DATA_WIDTH-1:0]      rsp_solution,
   output logic [1:0]                 rsp_status
);
   import mles_pkg::*;
   localparam int W  = DATA_WIDTH;
   localparam int SW = DATA_WIDTH + 1;
   localparam int CW = $clog2(DATA_WIDTH + 1);

   localparam logic [3:0] S_IDLE = 4'd0, S_EDIV = 4'd1, S_EWAIT = 4'd2, S_EUPD_S = 4'd3,
      S_EUPD_T = 4'd4, S_CHECK = 4'd5, S_DIVWAIT = 4'd6, S_MUL = 4'd7, S_FIN = 4'd8,
      S_OUT = 4'd9;
   // division job codes for the solution phase
   localparam logic [2:0] J_BD = 3'd0, J_BMOD = 3'd1, J_ND = 3'd2, J_NDMOD = 3'd3,
      J_KMOD = 3'd4, J_XMOD = 3'd5;

   logic [3:0] st_ff, st_in;
   logic [2:0] job_ff, job_in;
   logic [W-1:0] b_ff, b_in, n_ff, n_in, k_ff, k_in;
   logic [W-1:0] r0_ff, r0_in, r1_ff, r1_in, q_ff, q_in;
   logic [SW-1:0] s0_ff, s0_in, s1_ff, s1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0] bd_ff, bd_in, nd_ff, nd_in, kn_ff, kn_in;
   logic [W-1:0] sol_ff, sol_in, st1_ff, st1_in;
   logic [1:0]   stat_ff, stat_in;
   logic         xneg_ff, xneg_in, mph_ff, mph_in;
   // bit-serial modular multiply
   logic [W:0]   mp_ff, mp_in, acc_ff, acc_in;
   logic [W-1:0] mq_ff, mq_in;
   logic [CW-1:0] mc_ff, mc_in;
   logic [W:0]   acc_add, p_dbl;
   logic         vld_ff, vld_in;
   // output register
   logic [W-1:0]  out_gcd_ff, out_gcd_in, out_sol_ff, out_sol_in;
   logic [SW-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [1:0]    out_stat_ff, out_stat_in;

   logic div_start, div_done;
   logic [W-1:0] div_a, div_b, div_q, div_r;
   logic [SW-1:0] qx, prod_s;
   logic [W-1:0] s0mag;

   mles_div #(.DATA_WIDTH(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   assign qx    = {1'b0, q_ff};
   assign s0mag = W'(SW'(0) - s0_ff);

   always_comb begin
      st_in = st_ff; job_in = job_ff; b_in = b_ff; n_in = n_ff; k_in = k_ff;
      r0_in = r0_ff; r1_in = r1_ff; q_in = q_ff; s0_in = s0_ff; s1_in = s1_ff;
      t0_in = t0_ff; t1_in = t1_ff; bd_in = bd_ff; nd_in = nd_ff;
      kn_in = kn_ff; sol_in = sol_ff; st1_in = st1_ff; stat_in = stat_ff;
      xneg_in = xneg_ff; mph_in = mph_ff; mp_in = mp_ff; acc_in = acc_ff; mq_in = mq_ff;
      mc_in = mc_ff;
      out_gcd_in = out_gcd_ff; out_x_in = out_x_ff; out_y_in = out_y_ff;
      out_sol_in = out_sol_ff; out_stat_in = out_stat_ff;
      // drop the result once it is taken
      vld_in = vld_ff && !rsp_ready;
      div_start = 1'b0; div_a = r0_ff; div_b = r1_ff; prod_s = '0;
      acc_add = acc_ff + mp_ff;
      if (acc_add >= {1'b0, n_ff}) acc_add = acc_add - {1'b0, n_ff};
      p_dbl = {mp_ff[W-1:0], 1'b0};
      if (p_dbl >= {1'b0, n_ff}) p_dbl = p_dbl - {1'b0, n_ff};
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               b_in = req_rhs_b; n_in = req_modulus;
               k_in = req_solution_index;
               r0_in = req_coef_a; r1_in = req_modulus;
               s0_in = SW'(1); s1_in = '0; t0_in = '0; t1_in = SW'(1);
               sol_in = '0; st_in = S_EDIV;
            end
         end
         S_EDIV: begin
            if (r1_ff == '0) begin
               st_in = S_CHECK;
            end else begin
               div_start = 1'b1; st_in = S_EWAIT;
            end
         end
         S_EWAIT: begin
            if (div_done) begin
               q_in = div_q; r0_in = r1_ff; r1_in = div_r; st_in = S_EUPD_S;
            end
         end
         S_EUPD_S: begin
            prod_s = SW'(qx * s1_ff);
            s0_in = s1_ff; s1_in = s0_ff - prod_s; st_in = S_EUPD_T;
         end
         S_EUPD_T: begin
            prod_s = SW'(qx * t1_ff);
            t0_in = t1_ff; t1_in = t0_ff - prod_s; st_in = S_EDIV;
         end
         S_CHECK: begin
            // first job: b mod d decides divisibility
            if (n_ff == '0 || r0_ff == '0) begin
               stat_in = STATUS_NO_DIV; st_in = S_OUT;
            end else begin
               stat_in = STATUS_OK; job_in = J_BD; div_a = b_ff; div_b = r0_ff;
               div_start = 1'b1; st_in = S_DIVWAIT;
            end
         end
         S_DIVWAIT: begin
            if (div_done) begin
               div_start = 1'b1; st_in = S_DIVWAIT;
               case (job_ff)
                  J_BD: begin
                     if (div_r != '0) begin
                        stat_in = STATUS_NO_DIV; div_start = 1'b0; st_in = S_OUT;
                     end else if (k_ff >= r0_ff) begin
                        stat_in = STATUS_BAD_IDX; div_start = 1'b0; st_in = S_OUT;
                     end else begin
                        bd_in = div_q; div_a = div_q; div_b = n_ff; job_in = J_BMOD;
                     end
                  end
                  J_BMOD: begin
                     bd_in = div_r; div_a = n_ff; div_b = r0_ff; job_in = J_ND;
                  end
                  J_ND: begin
                     nd_in = div_q; div_a = div_q; div_b = n_ff; job_in = J_NDMOD;
                  end
                  J_NDMOD: begin
                     nd_in = div_r; div_a = k_ff; div_b = n_ff; job_in = J_KMOD;
                  end
                  J_KMOD: begin
                     kn_in = div_r; xneg_in = s0_ff[SW-1];
                     div_a = s0_ff[SW-1] ? s0mag : s0_ff[W-1:0];
                     div_b = n_ff; job_in = J_XMOD;
                  end
                  default: begin
                     div_start = 1'b0;
                     mp_in = {1'b0, (xneg_ff && div_r != '0) ? n_ff - div_r : div_r};
                     mq_in = bd_ff; acc_in = '0; mc_in = CW'(W); mph_in = 1'b0;
                     st_in = S_MUL;
                  end
               endcase
            end
         end
         S_MUL: begin
            // double-and-add, one multiplier bit a cycle
            if (mq_ff[0]) acc_in = acc_add;
            mp_in = p_dbl; mq_in = mq_ff >> 1; mc_in = mc_ff - 1'b1;
            if (mc_ff == CW'(1)) begin
               if (!mph_ff) begin
                  st1_in = mq_ff[0] ? acc_add[W-1:0] : acc_ff[W-1:0];
                  mp_in = {1'b0, kn_ff}; mq_in = nd_ff; acc_in = '0;
                  mc_in = CW'(W); mph_in = 1'b1;
               end else begin
                  st_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            acc_add = acc_ff + {1'b0, st1_ff};
            if (acc_add >= {1'b0, n_ff}) acc_add = acc_add - {1'b0, n_ff};
            sol_in = acc_add[W-1:0]; st_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!vld_ff || rsp_ready) begin
               out_gcd_in = r0_ff; out_x_in = s0_ff; out_y_in = t0_ff;
               out_sol_in = (stat_ff == STATUS_OK) ? sol_ff : '0;
               out_stat_in = stat_ff; vld_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign req_ready = (st_ff == S_IDLE);

   always_ff @(posedge clock) begin
      job_ff <= job_in; b_ff <= b_in; n_ff <= n_in; k_ff <= k_in;
      r0_ff <= r0_in; r1_ff <= r1_in; q_ff <= q_in; s0_ff <= s0_in; s1_ff <= s1_in;
      t0_ff <= t0_in; t1_ff <= t1_in; bd_ff <= bd_in; nd_ff <= nd_in;
      kn_ff <= kn_in; sol_ff <= sol_in; st1_ff <= st1_in; stat_ff <= stat_in;
      xneg_ff <= xneg_in; mph_ff <= mph_in; mp_ff <= mp_in; acc_ff <= acc_in;
      mq_ff <= mq_in; mc_ff <= mc_in;
      out_gcd_ff <= out_gcd_in; out_x_ff <= out_x_in; out_y_ff <= out_y_in;
      out_sol_ff <= out_sol_in; out_stat_ff <= out_stat_in;
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in;
      end
   end

   assign rsp_valid     = vld_ff;
   assign rsp_gcd_value = out_gcd_ff;
   assign rsp_bezout_x  = out_x_ff;
   assign rsp_bezout_y  = out_y_ff;
   assign rsp_solution  = out_sol_ff;
   assign rsp_status    = out_stat_ff;

   a_out_not_idle: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_OUT |=> vld_ff) else $error("result not presented");
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !req_ready) else $error("ready while busy");
   a_stat_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> out_stat_ff != 2'd3) else $error("bad status");
   a_sol_below_n: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_OUT && stat_ff == STATUS_OK |-> sol_ff < n_ff)
      else $error("solution not reduced");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp_ready |=> vld_ff && $stable(out_gcd_ff) && $stable(out_sol_ff))
      else $error("result changed while waiting");
endmodule
`default_nettype wire

### rtl/mles_div.sv
// Restoring divider, one quotient bit per cycle.
// Shared unit of the solver; no dependencies.
`default_nettype none
module mles_div #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DATA_WIDTH-1:0] dividend,
   input  wire logic [DATA_WIDTH-1:0] divisor,
   output logic                       done,
   output logic [DATA_WIDTH-1:0]      quotient,
   output logic [DATA_WIDTH-1:0]      remainder
);
   localparam int CW = $clog2(DATA_WIDTH + 1);
   logic [DATA_WIDTH-1:0] q_ff, q_in, d_ff, d_in;
   logic [DATA_WIDTH:0]   r_ff, r_in, trial;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DATA_WIDTH-1:0], q_ff[DATA_WIDTH-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; d_in = divisor; r_in = '0;
         cnt_in = CW'(DATA_WIDTH); busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, keep the trial difference if nonnegative
         if (!trial[DATA_WIDTH]) begin
            r_in = trial;
            q_in = {q_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DATA_WIDTH-1:0], q_ff[DATA_WIDTH-1]};
            q_in = {q_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff[DATA_WIDTH-1:0];

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff && d_ff != '0 |-> r_ff[DATA_WIDTH-1:0] < d_ff)
      else $error("remainder not below divisor");
endmodule
`default_nettype wire
